/* rtl/windowed_average_min_tracker_top_macros.svh */
// assertion macros for the windowed average / minimum tracker
// used by windowed_average_min_tracker_top, which provides clock and reset
`ifndef WINDOWED_AVERAGE_MIN_TRACKER_TOP_MACROS_SVH
`define WINDOWED_AVERAGE_MIN_TRACKER_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define WAMT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define WAMT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define WAMT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/wamt_pkg.sv */
// shared widths and defaults for the windowed average / minimum tracker
// no dependencies
package wamt_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int AVG_W          = SAMPLE_BITS + 1;
   localparam int DIFF_W         = SAMPLE_BITS + 2;
   localparam int WINDOW_LEN_DEF = 1001;

endpackage

/* rtl/wamt_req_if.sv */
// sample channel: valid/ready handshake carrying one duration sample per beat
// depends on wamt_pkg
interface wamt_req_if import wamt_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_time;

   modport source (output valid, output sample_time, input ready);
   modport sink (input valid, input sample_time, output ready);

endinterface

/* rtl/wamt_rsp_if.sv */
// result channel: valid/ready handshake carrying average, minimum and difference
// depends on wamt_pkg
interface wamt_rsp_if import wamt_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic signed [AVG_W-1:0]  new_average;
   logic [SAMPLE_BITS-1:0]   new_minimum;
   logic signed [DIFF_W-1:0] diff_to_average;
   logic                     diff_valid;

   modport source (output valid, output new_average, output new_minimum,
                   output diff_to_average, output diff_valid, input ready);
   modport sink (input valid, input new_average, input new_minimum,
                 input diff_to_average, input diff_valid, output ready);

endinterface

/* rtl/windowed_average_min_tracker_top.sv */
// a sample beat is taken in S_IDLE and walks S_READ, S_MUL, S_ADD, S_DIV and S_FIN; the
// result beat is registered when S_FIN finds the output free, and no new sample is taken before that
// the average is formed by a bit-serial shift-add multiply over the count bits followed by a
// restoring divider that yields one quotient bit a cycle
// synchronous reset clears count, pointer, average and minimum; history ram is not cleared
// depends on wamt_pkg, wamt_req_if, wamt_rsp_if and the assertion macro header
`include "windowed_average_min_tracker_top_macros.svh"

module windowed_average_min_tracker_top import wamt_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
   input logic        clock,
   input logic        reset,
   wamt_req_if.sink   req_bus,
   wamt_rsp_if.source rsp_bus
);

   localparam int CNT_W    = $clog2(WINDOW_LEN + 1);
   localparam int PTR_W    = $clog2(WINDOW_LEN);
   localparam int Q_W      = AVG_W;
   localparam int PROD_W   = AVG_W + CNT_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int TERM_W   = SAMPLE_BITS + 1;
   localparam int STEP_MAX = (CNT_W > Q_W) ? CNT_W : Q_W;
   localparam int STEP_W   = $clog2(STEP_MAX);

   localparam logic [CNT_W-1:0]       WIN_CNT  = CNT_W'(WINDOW_LEN);
   localparam logic [PTR_W-1:0]       LAST_PTR = PTR_W'(WINDOW_LEN - 1);
   localparam logic signed [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
   localparam logic signed [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_READ = 6'b000010,
      S_MUL  = 6'b000100,
      S_ADD  = 6'b001000,
      S_DIV  = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0]   smp_ff, smp_in;
   logic                     dv_ff, dv_in;
   logic [SAMPLE_BITS-1:0]   min_ff, min_in;
   logic                     min_vld_ff, min_vld_in;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     full_ff, full_in;
   logic [CNT_W-1:0]         mlen_ff, mlen_in;
   logic [CNT_W-1:0]         dlen_ff, dlen_in;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [Q_W-1:0]           dq_ff, dq_in;
   logic                     neg_ff, neg_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [AVG_W-1:0]  avg_ff, avg_in;

   logic signed [AVG_W-1:0]  o_avg_ff, o_avg_in;
   logic [SAMPLE_BITS-1:0]   o_min_ff, o_min_in;
   logic signed [DIFF_W-1:0] o_diff_ff, o_diff_in;
   logic                     o_dv_ff, o_dv_in;
   logic                     o_vld_ff, o_vld_in;

   logic [SAMPLE_BITS-1:0]   hist_mem [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0]   rd_ff;

   logic                     req_fire;
   logic                     rsp_fire;
   logic                     out_free;
   logic                     mem_wr;
   logic [SAMPLE_BITS-1:0]   dropped;
   logic signed [PROD_W-1:0] addend;
   logic signed [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]         mag;
   logic [CNT_W:0]           shifted;
   logic [CNT_W+1:0]         trial;
   logic                     take;
   logic signed [AVG_W-1:0]  avg_new;
   logic signed [DIFF_W-1:0] diff_new;

   assign req_bus.ready = (state_ff == S_IDLE) && !reset;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = o_vld_ff && rsp_bus.ready;
   assign out_free      = !o_vld_ff || rsp_bus.ready;
   assign mem_wr        = (state_ff == S_READ);

   assign rsp_bus.valid           = o_vld_ff;
   assign rsp_bus.new_average     = o_avg_ff;
   assign rsp_bus.new_minimum     = o_min_ff;
   assign rsp_bus.diff_to_average = o_diff_ff;
   assign rsp_bus.diff_valid      = o_dv_ff;

   // datapath terms
   always_comb begin
      dropped = full_ff ? rd_ff : '0;
      addend  = mlen_ff[CNT_W-1] ? PROD_W'(avg_ff) : '0;
      sum     = SUM_W'(acc_ff) + SUM_W'(term_ff);
      mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      shifted = {rem_ff, dq_ff[Q_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dlen_ff};
      take    = !trial[CNT_W+1];
      // saturate the signed quotient to the average range
      if (!neg_ff) begin
         avg_new = dq_ff[Q_W-1] ? AVG_MAX : $signed(dq_ff);
      end else if (dq_ff[Q_W-1] && (|dq_ff[Q_W-2:0])) begin
         avg_new = AVG_MIN;
      end else begin
         avg_new = $signed(-dq_ff);
      end
      diff_new = dv_ff ? ($signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, smp_ff}) - DIFF_W'(avg_ff))
                       : '0;
   end

   always_comb begin
      state_in   = state_ff;
      smp_in     = smp_ff;
      dv_in      = dv_ff;
      min_in     = min_ff;
      min_vld_in = min_vld_ff;
      wp_in      = wp_ff;
      cnt_in     = cnt_ff;
      full_in    = full_ff;
      mlen_in    = mlen_ff;
      dlen_in    = dlen_ff;
      term_in    = term_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      neg_in     = neg_ff;
      step_in    = step_ff;
      avg_in     = avg_ff;
      o_avg_in   = o_avg_ff;
      o_min_in   = o_min_ff;
      o_diff_in  = o_diff_ff;
      o_dv_in    = o_dv_ff;
      o_vld_in   = o_vld_ff;

      if (rsp_fire) begin
         o_vld_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               smp_in = req_bus.sample_time;
               dv_in  = min_vld_ff;
               if (!min_vld_ff || (req_bus.sample_time < min_ff)) begin
                  min_in     = req_bus.sample_time;
                  min_vld_in = 1'b1;
               end
               mlen_in = cnt_ff;
               if (cnt_ff == WIN_CNT) begin
                  full_in = 1'b1;
                  dlen_in = cnt_ff;
               end else begin
                  full_in = 1'b0;
                  dlen_in = cnt_ff + 1'b1;
                  cnt_in  = cnt_ff + 1'b1;
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            // oldest entry is out of the ram now, slot takes the new sample
            term_in  = $signed({1'b0, smp_ff}) - $signed({1'b0, dropped});
            wp_in    = (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;
            acc_in   = '0;
            step_in  = STEP_W'(CNT_W - 1);
            state_in = S_MUL;
         end
         S_MUL: begin
            // msb-first shift-add of average times old count
            acc_in  = (acc_ff <<< 1) + addend;
            mlen_in = mlen_ff << 1;
            if (step_ff == '0) begin
               state_in = S_ADD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_ADD: begin
            // quotient magnitude stays below 2^Q_W, so the top bits start as remainder
            neg_in   = sum[SUM_W-1];
            rem_in   = CNT_W'(mag >> Q_W);
            dq_in    = mag[Q_W-1:0];
            step_in  = STEP_W'(Q_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = take ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
            dq_in  = {dq_ff[Q_W-2:0], take};
            if (step_ff == '0) begin
               state_in = S_FIN;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               avg_in    = avg_new;
               o_avg_in  = avg_new;
               o_min_in  = min_ff;
               o_diff_in = diff_new;
               o_dv_in   = dv_ff;
               o_vld_in  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         min_vld_ff <= 1'b0;
         min_ff     <= '0;
         wp_ff      <= '0;
         cnt_ff     <= '0;
         avg_ff     <= '0;
         o_vld_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         min_vld_ff <= min_vld_in;
         min_ff     <= min_in;
         wp_ff      <= wp_in;
         cnt_ff     <= cnt_in;
         avg_ff     <= avg_in;
         o_vld_ff   <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff    <= smp_in;
      dv_ff     <= dv_in;
      full_ff   <= full_in;
      mlen_ff   <= mlen_in;
      dlen_ff   <= dlen_in;
      term_ff   <= term_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      dq_ff     <= dq_in;
      neg_ff    <= neg_in;
      step_ff   <= step_in;
      o_avg_ff  <= o_avg_in;
      o_min_ff  <= o_min_in;
      o_diff_ff <= o_diff_in;
      o_dv_ff   <= o_dv_in;
   end

   // history ram, read on the sample beat and written the cycle after
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= hist_mem[wp_ff];
      end
      if (mem_wr) begin
         hist_mem[wp_ff] <= smp_ff;
      end
   end

   `WAMT_ASSERT_ALWAYS(a_cnt_range, cnt_ff <= WIN_CNT, "entry count beyond window length")
   `WAMT_ASSERT_ALWAYS(a_ptr_range, wp_ff <= LAST_PTR, "write pointer beyond window")
   `WAMT_ASSERT_IMP(a_min_has_entry, min_vld_ff, cnt_ff != '0, "minimum held with empty history")
   `WAMT_ASSERT_IMP(a_rem_bound, state_ff == S_DIV, rem_ff < dlen_ff, "divider remainder not below count")
   `WAMT_ASSERT_NXT(a_beat_reads, req_fire, state_ff == S_READ, "sample beat did not start ram read")

endmodule

/* tb/windowed_average_min_tracker_top_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for windowed_average_min_tracker_top: predicts average, minimum and
// difference per sample beat and compares every result beat in order
// depends on wamt_pkg, wamt_req_if, wamt_rsp_if and the tracker rtl
module windowed_average_min_tracker_top_tb import wamt_pkg::*; ();

   localparam int      WIN           = WINDOW_LEN_DEF;
   localparam int      HIST_PTR_W    = $clog2(WIN);
   localparam int      CLK_PERIOD    = 12;
   localparam int      BLOCK_CYCLES  = $clog2(WIN + 1) + SAMPLE_BITS + 4;
   localparam int      DRAIN_LIMIT   = 20000;
   localparam int      HOLD_OFF_LEN  = 400;
   localparam longint  TIMEOUT_NS    = 64'd2_000_000 * CLK_PERIOD;
   localparam longint  AVG_HI        = (longint'(1) << SAMPLE_BITS) - 1;
   localparam longint  AVG_LO        = -(longint'(1) << SAMPLE_BITS);

   typedef enum int {
      MIX_GENERAL,
      MIX_HIGH,
      MIX_LOW
   } duration_mix_type;

   typedef struct {
      logic signed [AVG_W-1:0]  average;
      logic [SAMPLE_BITS-1:0]   minimum;
      logic signed [DIFF_W-1:0] diff;
      logic                     diff_ok;
   } window_stats_type;

   logic clock;
   logic reset;

   wamt_req_if req_if ();
   wamt_rsp_if rsp_if ();

   windowed_average_min_tracker_top #(
      .WINDOW_LEN(WIN)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if)
   );

   // predicted tracker state
   logic [SAMPLE_BITS-1:0] hist_mem [WIN];
   int unsigned            hist_wr_ptr = 0;
   int unsigned            hist_fill   = 0;
   longint                 avg_state   = 0;
   logic [SAMPLE_BITS-1:0] min_state   = '0;
   bit                     min_seen    = 1'b0;

   window_stats_type stats_in_flight [$];

   int     error_count     = 0;
   int     samples_sent    = 0;
   int     results_checked = 0;
   int     window_wraps    = 0;
   longint lowest_avg      = 0;
   longint highest_avg     = 0;
   bit     req_gaps_on     = 1'b1;
   bit     rsp_gaps_on     = 1'b1;
   int     hold_off_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 3);
      if (r < 93) return $urandom_range(4, 16);
      return $urandom_range(30, 90);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_duration(input duration_mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_HIGH: begin
            if (r < 70) return {SAMPLE_BITS{1'b1}} - SAMPLE_BITS'($urandom_range(0, 4095));
         end
         MIX_LOW: begin
            if (r < 70) return SAMPLE_BITS'($urandom_range(0, 255));
         end
         default: begin
            if (r < 20) return SAMPLE_BITS'($urandom_range(0, 1023));
            if (r < 40) return {SAMPLE_BITS{1'b1}} - SAMPLE_BITS'($urandom_range(0, 1023));
            if (r < 55) return SAMPLE_BITS'(24'h400000 + $urandom_range(0, 4095) - 2048);
            if (r < 65) return SAMPLE_BITS'(1 << $urandom_range(0, SAMPLE_BITS - 1));
         end
      endcase
      return SAMPLE_BITS'($urandom);
   endfunction

   // one step of the window: diff against the old average, then min, history and new average
   function automatic window_stats_type next_window_stats(input logic [SAMPLE_BITS-1:0] s);
      window_stats_type r;
      longint           s_val;
      longint           dropped;
      longint           old_len;
      longint           new_len;
      longint           acc;
      longint           q;
      s_val     = longint'(s);
      dropped   = 0;
      r.diff_ok = min_seen;
      r.diff    = min_seen ? DIFF_W'(s_val - avg_state) : '0;
      if (!min_seen || s < min_state) begin
         min_state = s;
         min_seen  = 1'b1;
      end
      old_len = longint'(hist_fill);
      // full history: the oldest entry leaves before its slot is reused
      if (hist_fill == WIN) begin
         dropped = longint'(hist_mem[hist_wr_ptr[HIST_PTR_W-1:0]]);
      end else begin
         hist_fill++;
      end
      new_len = longint'(hist_fill);
      hist_mem[hist_wr_ptr[HIST_PTR_W-1:0]] = s;
      if (hist_wr_ptr == WIN - 1) begin
         hist_wr_ptr = 0;
         window_wraps++;
      end else begin
         hist_wr_ptr++;
      end
      acc = avg_state * old_len + (s_val - dropped);
      q   = acc / new_len;
      if (q > AVG_HI) q = AVG_HI;
      if (q < AVG_LO) q = AVG_LO;
      avg_state = q;
      if (q < lowest_avg) lowest_avg = q;
      if (q > highest_avg) highest_avg = q;
      r.average = AVG_W'(q);
      r.minimum = min_state;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint want, input longint got);
      error_count++;
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endtask

   task automatic check_window_stats();
      window_stats_type want;
      if (stats_in_flight.size() == 0) begin
         error_count++;
         $error("result beat with no sample pending");
      end else begin
         want = stats_in_flight.pop_front();
         results_checked++;
         if (rsp_if.new_average !== want.average)
            report_mismatch("new_average", longint'(want.average),
                            longint'(rsp_if.new_average));
         if (rsp_if.new_minimum !== want.minimum)
            report_mismatch("new_minimum", longint'(want.minimum),
                            longint'(rsp_if.new_minimum));
         if (rsp_if.diff_to_average !== want.diff)
            report_mismatch("diff_to_average", longint'(want.diff),
                            longint'(rsp_if.diff_to_average));
         if (rsp_if.diff_valid !== want.diff_ok)
            report_mismatch("diff_valid", longint'(want.diff_ok),
                            longint'(rsp_if.diff_valid));
      end
   endtask

   // result side: checks each beat and owns ready
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) check_window_stats();
         if (hold_off_cycles > 0) begin
            stall_left      = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap() - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // valid stays high across back-to-back beats
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
      int gap;
      gap = (req_gaps_on && $urandom_range(0, 1)) ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.sample_time <= s;
      do @(posedge clock); while (!req_if.ready);
      stats_in_flight.push_back(next_window_stats(s));
      samples_sent++;
   endtask

   task automatic wait_for_results();
      int cycles;
      cycles = 0;
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
         cycles++;
      end while (stats_in_flight.size() != 0 && cycles < DRAIN_LIMIT);
   endtask

   task automatic test_first_and_extremes();
      logic [SAMPLE_BITS-1:0] pattern [14] = '{
         24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'hAAAAAA, 24'h555555,
         24'h000002, 24'h000001, 24'h000001, 24'h000000, 24'hFFFFFF, 24'h000000,
         24'h000000, 24'hFFFFFF
      };
      foreach (pattern[i]) send_sample(pattern[i]);
   endtask

   // run the history past full so the oldest entries start dropping out
   task automatic test_window_full_wrap();
      while (samples_sent < WIN + 64) send_sample(random_duration(MIX_GENERAL));
   endtask

   // rotating general, high and low bursts pull the truncated average around
   task automatic test_random_mix();
      for (int i = 0; i < 600; i++)
         send_sample(random_duration(duration_mix_type'((i / 64) % 3)));
   endtask

   task automatic test_receiver_hold_off();
      req_gaps_on     = 1'b0;
      hold_off_cycles = HOLD_OFF_LEN;
      for (int i = 0; i < 30; i++) send_sample(random_duration(MIX_GENERAL));
      req_gaps_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      for (int i = 0; i < 20; i++) send_sample(random_duration(MIX_HIGH));
      wait_for_results();
      for (int i = 0; i < 20; i++) send_sample(random_duration(MIX_LOW));
   endtask

   task automatic test_back_to_back();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      for (int i = 0; i < 150; i++) send_sample(random_duration(MIX_GENERAL));
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.sample_time <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_first_and_extremes();
      test_window_full_wrap();
      test_random_mix();
      test_receiver_hold_off();
      test_sender_pause();
      test_back_to_back();

      wait_for_results();
      repeat (BLOCK_CYCLES + 20) @(posedge clock);
      if (stats_in_flight.size() != 0) begin
         error_count++;
         $error("%0d results never arrived", stats_in_flight.size());
      end

      $display("tb: %0d duration samples sent, %0d result beats compared", samples_sent,
               results_checked);
      $display("tb: history wrapped %0d times, average spanned %0d to %0d", window_wraps,
               lowest_avg, highest_avg);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
